[rtl/i2cms_pkg.sv]
`default_nettype none
package i2cms_pkg;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam int unsigned HALF_W = 16;
   localparam logic [HALF_W-1:0] HALF_RESET = 16'd5;
   localparam logic [3:0] ACK_SLOT = 4'd8;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_HIGH
   } phase_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       nack_after;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_error;
   } result_type;

endpackage
`default_nettype wire

[rtl/i2c_master_byte_sequencer_core.sv]
`default_nettype none
// Channel   Handshake          Payload
// req       push / full        req_operation, req_data_byte, req_nack_after, req_sda_in
// rsp       empty / pop        rsp_scl_level, rsp_sda_pull_low, rsp_busy_res,
//                              rsp_done_res, rsp_read_data, rsp_ack_error
// csr       csr_we             csr_wdata (SCL half period in base ticks)
//
// One beat in, one beat out; the engine takes one queued beat per cycle while the result buffer has room.
// A beat is registered first in the command queue, then through the engine
// into the two-entry result buffer. The queue holds QUEUE_DEPTH beats.
// Reset is synchronous: queues empty, SCL high, SDA released, half period 5.
// A stalled pop holds the engine once the result buffer fills; full then rises.
module i2c_master_byte_sequencer_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_operation,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_nack_after,
   input  wire logic        req_sda_in,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_scl_level,
   output logic             rsp_sda_pull_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_ack_error,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);
   import i2cms_pkg::*;

   logic       head_valid;
   logic       head_pop;
   item_type   head_item;
   result_type result;

   i2cms_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .operation  (req_operation),
      .data_byte  (req_data_byte),
      .nack_after (req_nack_after),
      .sda_in     (req_sda_in),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   i2cms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .empty      (empty),
      .pop        (pop),
      .result     (result)
   );

   assign rsp_scl_level    = result.scl_level;
   assign rsp_sda_pull_low = result.sda_pull_low;
   assign rsp_busy_res     = result.busy_res;
   assign rsp_done_res     = result.done_res;
   assign rsp_read_data    = result.read_data;
   assign rsp_ack_error    = result.ack_error;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_done_res) |-> !rsp_busy_res)
      else $error("done beat still reports busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result beat lost");

   a_engine_moves: assert property (@(posedge clock) disable iff (reset)
      (head_valid && empty) |=> !empty)
      else $error("engine stalled with room in result buffer");

endmodule
`default_nettype wire

[rtl/i2cms_front.sv]
`default_nettype none
module i2cms_front #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic [2:0]          operation,
   input  wire logic [7:0]          data_byte,
   input  wire logic                nack_after,
   input  wire logic                sda_in,
   output logic                     head_valid,
   output i2cms_pkg::item_type      head_item,
   input  wire logic                head_pop
);
   import i2cms_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         decoded;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      decoded.data_byte  = data_byte;
      decoded.nack_after = nack_after;
      decoded.sda_in     = sda_in;
      unique case (operation)
         OP_START: decoded.cmd = CMD_START;
         OP_STOP:  decoded.cmd = CMD_STOP;
         OP_WRITE: decoded.cmd = CMD_WRITE;
         OP_READ:  decoded.cmd = CMD_READ;
         default:  decoded.cmd = CMD_TICK;
      endcase
   end

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

[rtl/i2cms_back.sv]
`default_nettype none
module i2cms_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 head_valid,
   input  wire i2cms_pkg::item_type  head_item,
   output logic                      head_pop,
   output logic                      empty,
   input  wire logic                 pop,
   output i2cms_pkg::result_type     result
);
   import i2cms_pkg::*;

   logic [HALF_W-1:0] half_ff;
   phase_type         phase_ff, phase_in;
   logic [3:0]        bit_ff, bit_in;
   logic [7:0]        shift_ff, shift_in;
   logic [HALF_W-1:0] tick_ff, tick_in;
   cmd_type           op_ff, op_in;
   logic              nack_ff, nack_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic              ackerr_ff, ackerr_in;

   result_type        out_q_ff [2];
   logic              out_wr_ff, out_rd_ff;
   logic [1:0]        out_cnt_ff, out_cnt_in;

   logic [HALF_W-1:0] half_eff;
   logic [HALF_W:0]   tick_next;
   logic              half_end;
   logic              start_cmd;
   logic              step;
   logic              done;
   logic [7:0]        shifted;
   logic [3:0]        bit_next;
   logic              out_pop;
   result_type        step_result;

   assign half_eff  = (half_ff == '0) ? HALF_W'(1) : half_ff;
   assign tick_next = {1'b0, tick_ff} + 1'b1;
   assign half_end  = (phase_ff != PH_IDLE) && (tick_next >= {1'b0, half_eff});
   assign start_cmd = (phase_ff == PH_IDLE) && (head_item.cmd != CMD_TICK);
   assign step      = head_valid && (out_cnt_ff != 2'd2);
   assign head_pop  = step;
   assign shifted   = (op_ff == CMD_WRITE) ? {shift_ff[6:0], 1'b0} : shift_ff;
   assign bit_next  = bit_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_cmd) begin
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            if (half_end) begin
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            if (half_end) begin
               if (op_ff == CMD_START || op_ff == CMD_STOP || bit_ff >= ACK_SLOT) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_LOW;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      tick_in   = tick_ff;
      op_in     = op_ff;
      nack_in   = nack_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      rdata_in  = rdata_ff;
      ackerr_in = ackerr_ff;
      done      = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start_cmd) begin
            op_in   = head_item.cmd;
            tick_in = '0;
            bit_in  = '0;
            unique case (head_item.cmd)
               CMD_START: begin
                  scl_in = 1'b1;
                  sda_in = 1'b0;
               end
               CMD_STOP: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end
               CMD_WRITE: begin
                  shift_in = head_item.data_byte;
                  nack_in  = head_item.nack_after;
                  scl_in   = 1'b0;
                  sda_in   = ~head_item.data_byte[7];
               end
               default: begin
                  shift_in = '0;
                  nack_in  = head_item.nack_after;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end
            endcase
         end
      end else if (!half_end) begin
         tick_in = tick_next[HALF_W-1:0];
      end else begin
         tick_in = '0;
         if (phase_ff == PH_LOW) begin
            if (op_ff == CMD_READ && bit_ff < ACK_SLOT) begin
               shift_in = {shift_ff[6:0], head_item.sda_in};
            end
            if (op_ff == CMD_WRITE && bit_ff == ACK_SLOT) begin
               ackerr_in = head_item.sda_in;
            end
            scl_in = 1'b1;
            if (op_ff == CMD_START) begin
               sda_in = 1'b1;
            end
         end else if (op_ff == CMD_START) begin
            done = 1'b1;
         end else if (op_ff == CMD_STOP) begin
            sda_in = 1'b0;
            done   = 1'b1;
         end else if (bit_ff >= ACK_SLOT) begin
            if (op_ff == CMD_WRITE) begin
               scl_in = 1'b0;
            end else begin
               rdata_in = shift_ff;
            end
            done = 1'b1;
         end else begin
            shift_in = shifted;
            bit_in   = bit_next;
            scl_in   = 1'b0;
            if (bit_next < ACK_SLOT) begin
               sda_in = (op_ff == CMD_WRITE) ? ~shifted[7] : 1'b0;
            end else begin
               sda_in = (op_ff == CMD_WRITE) ? 1'b0 : ~nack_ff;
            end
         end
      end
   end

   always_comb begin
      step_result.scl_level    = scl_in;
      step_result.sda_pull_low = sda_in;
      step_result.busy_res     = (phase_in != PH_IDLE);
      step_result.done_res     = done;
      step_result.read_data    = rdata_in;
      step_result.ack_error    = ackerr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= HALF_RESET;
         phase_ff  <= PH_IDLE;
         bit_ff    <= '0;
         shift_ff  <= '0;
         tick_ff   <= '0;
         op_ff     <= CMD_TICK;
         nack_ff   <= 1'b0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b0;
         rdata_ff  <= '0;
         ackerr_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            half_ff <= csr_wdata;
         end
         if (step) begin
            phase_ff  <= phase_in;
            bit_ff    <= bit_in;
            shift_ff  <= shift_in;
            tick_ff   <= tick_in;
            op_ff     <= op_in;
            nack_ff   <= nack_in;
            scl_ff    <= scl_in;
            sda_ff    <= sda_in;
            rdata_ff  <= rdata_in;
            ackerr_ff <= ackerr_in;
         end
      end
   end

   assign empty   = (out_cnt_ff == 2'd0);
   assign out_pop = pop && !empty;
   assign result  = out_q_ff[out_rd_ff];

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (step && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !step) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         if (step) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_q_ff[out_wr_ff] <= step_result;
      end
   end

endmodule
`default_nettype wire

[test/tb_i2c_master_byte_sequencer_core.sv]
`timescale 1ns / 1ps
module tb_i2c_master_byte_sequencer_core;
   import i2cms_pkg::*;

   localparam logic [2:0] OP_RSVD_A = OP_READ + 3'd1;
   localparam logic [2:0] OP_RSVD_B = OP_READ + 3'd2;
   localparam logic [2:0] OP_RSVD_C = OP_READ + 3'd3;
   localparam result_type RES_IDLE = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
   localparam result_type RES_START_DONE = '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0};
   localparam result_type RES_STOP_DONE = '{1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0};

   typedef struct {
      logic [2:0] op;
      logic [7:0] data;
      logic       nack;
      logic       sda;
      bit         typed;
      result_type want;
   } step_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_operation = OP_TICK;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_nack_after = 1'b0;
   logic        req_sda_in = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_pull_low;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_error;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned mismatches = 0;

   result_type bus_expect_q[$];
   result_type head;
   step_row    dir_rows[$];
   logic [2:0] pending_ops[$];

   logic [15:0] half_ticks = HALF_RESET;
   phase_type   eng_phase = PH_IDLE;
   logic [3:0]  eng_bit = 4'd0;
   logic [7:0]  eng_shift = 8'h00;
   int unsigned eng_ticks = 0;
   logic [2:0]  eng_op = OP_TICK;
   logic        eng_nack = 1'b0;
   logic        eng_scl = 1'b1;
   logic        eng_sda_low = 1'b0;
   logic [7:0]  eng_rdata = 8'h00;
   logic        eng_ackerr = 1'b0;

   i2c_master_byte_sequencer_core uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_operation(req_operation),
      .req_data_byte(req_data_byte),
      .req_nack_after(req_nack_after),
      .req_sda_in(req_sda_in),
      .empty(empty),
      .pop(pop),
      .rsp_scl_level(rsp_scl_level),
      .rsp_sda_pull_low(rsp_sda_pull_low),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_read_data(rsp_read_data),
      .rsp_ack_error(rsp_ack_error),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function void enter_low_half();
      eng_phase = PH_LOW;
      eng_scl = 1'b0;
      if (eng_bit < ACK_SLOT) begin
         eng_sda_low = (eng_op == OP_WRITE) ? ~eng_shift[7] : 1'b0;
      end else begin
         eng_sda_low = (eng_op == OP_WRITE) ? 1'b0 : ~eng_nack;
      end
   endfunction

   task automatic bus_engine_step(input logic [2:0] op, input logic [7:0] data,
                                  input logic nack, input logic sda,
                                  output result_type r);
      int unsigned half;
      logic        done;
      half = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
      done = 1'b0;
      if (eng_phase == PH_IDLE) begin
         if (op >= OP_START && op <= OP_READ) begin
            eng_op = op;
            eng_ticks = 0;
            eng_bit = 4'd0;
            case (op)
               OP_START: begin
                  eng_phase = PH_LOW;
                  eng_scl = 1'b1;
                  eng_sda_low = 1'b0;
               end
               OP_STOP: begin
                  eng_phase = PH_LOW;
                  eng_scl = 1'b0;
                  eng_sda_low = 1'b1;
               end
               default: begin
                  eng_shift = (op == OP_WRITE) ? data : 8'h00;
                  eng_nack = nack;
                  enter_low_half();
               end
            endcase
         end
      end else begin
         eng_ticks++;
         if (eng_ticks >= half) begin
            eng_ticks = 0;
            if (eng_phase == PH_LOW) begin
               if (eng_op == OP_READ && eng_bit < ACK_SLOT) eng_shift = {eng_shift[6:0], sda};
               if (eng_op == OP_WRITE && eng_bit == ACK_SLOT) eng_ackerr = sda;
               eng_phase = PH_HIGH;
               eng_scl = 1'b1;
               if (eng_op == OP_START) eng_sda_low = 1'b1;
            end else if (eng_op == OP_START) begin
               eng_phase = PH_IDLE;
               done = 1'b1;
            end else if (eng_op == OP_STOP) begin
               eng_sda_low = 1'b0;
               eng_phase = PH_IDLE;
               done = 1'b1;
            end else if (eng_bit >= ACK_SLOT) begin
               if (eng_op == OP_WRITE) eng_scl = 1'b0;
               else eng_rdata = eng_shift;
               eng_phase = PH_IDLE;
               done = 1'b1;
            end else begin
               if (eng_op == OP_WRITE) eng_shift = {eng_shift[6:0], 1'b0};
               eng_bit++;
               enter_low_half();
            end
         end
      end
      r.scl_level = eng_scl;
      r.sda_pull_low = eng_sda_low;
      r.busy_res = (eng_phase != PH_IDLE);
      r.done_res = done;
      r.read_data = eng_rdata;
      r.ack_error = eng_ackerr;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (bus_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: result beat with nothing expected", $time);
         end else begin
            head = bus_expect_q.pop_front();
            check_field("scl_level", head.scl_level, rsp_scl_level);
            check_field("sda_pull_low", head.sda_pull_low, rsp_sda_pull_low);
            check_field("busy_res", head.busy_res, rsp_busy_res);
            check_field("done_res", head.done_res, rsp_done_res);
            check_field("read_data", head.read_data, rsp_read_data);
            check_field("ack_error", head.ack_error, rsp_ack_error);
         end
      end
   end

   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
   end

   task automatic send_beat(input logic [2:0] op, input logic [7:0] data, input logic nack,
                            input logic sda, input bit typed, input result_type want);
      result_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_nack_after <= nack;
      req_sda_in <= sda;
      do @(posedge clock); while (full);
      bus_engine_step(op, data, nack, sda, r);
      bus_expect_q.push_back(typed ? want : r);
   endtask

   task automatic set_half_period(input logic [15:0] value);
      push <= 1'b0;
      while (bus_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      half_ticks = value;
   endtask

   task automatic run_phase(input logic [15:0] half, input int unsigned tx,
                            input int unsigned rx, input int unsigned count);
      logic [2:0]  op;
      logic [7:0]  data;
      logic        nack;
      logic        sda;
      int unsigned pick;
      set_half_period(half);
      tx_idle_pct = tx;
      rx_stall_pct = rx;
      repeat (count) begin
         sda = 1'($urandom_range(1));
         nack = 1'($urandom_range(1));
         case ($urandom_range(7))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom_range(255));
         endcase
         if (eng_phase == PH_IDLE) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               op = 3'($urandom_range(7));
            end else if (pick < 25) begin
               op = OP_TICK;
            end else begin
               if (pending_ops.size() == 0) begin
                  pending_ops.push_back(OP_START);
                  pending_ops.push_back(OP_WRITE);
                  repeat ($urandom_range(3))
                     pending_ops.push_back($urandom_range(1) ? OP_READ : OP_WRITE);
                  // drop the stop now and then to leave a broken transfer
                  if ($urandom_range(9) != 0) pending_ops.push_back(OP_STOP);
               end
               op = pending_ops.pop_front();
            end
         end else begin
            op = ($urandom_range(99) < 85) ? OP_TICK : 3'($urandom_range(7));
         end
         send_beat(op, data, nack, sda, 1'b0, '0);
      end
   endtask

   function automatic step_row mk_row(input logic [2:0] op, input logic [7:0] data,
                                      input logic nack, input logic sda, input bit typed,
                                      input result_type want);
      step_row s;
      s.op = op;
      s.data = data;
      s.nack = nack;
      s.sda = sda;
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   initial begin
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 1, RES_IDLE));
      dir_rows.push_back(mk_row(OP_RSVD_A, 8'hFF, 1'b1, 1'b1, 1, RES_IDLE));
      dir_rows.push_back(mk_row(OP_RSVD_B, 8'h00, 1'b0, 1'b1, 1, RES_IDLE));
      dir_rows.push_back(mk_row(OP_RSVD_C, 8'hFF, 1'b1, 1'b0, 1, RES_IDLE));
      dir_rows.push_back(mk_row(OP_START, 8'h00, 1'b0, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_STOP, 8'hFF, 1'b1, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_WRITE, 8'h00, 1'b0, 1'b0, 1, RES_START_DONE));
      dir_rows.push_back(mk_row(OP_STOP, 8'h00, 1'b0, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_READ, 8'h00, 1'b1, 1'b1, 1, RES_STOP_DONE));
      dir_rows.push_back(mk_row(OP_WRITE, 8'hFF, 1'b1, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_RSVD_A, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_READ, 8'hFF, 1'b1, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_START, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_STOP, 8'hFF, 1'b1, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_WRITE, 8'h00, 1'b0, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_RSVD_C, 8'hFF, 1'b1, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 0, '0));
      dir_rows.push_back(mk_row(OP_RSVD_B, 8'hFF, 1'b1, 1'b0, 0, '0));
      dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_half_period(16'd1);
      foreach (dir_rows[i])
         send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].nack, dir_rows[i].sda,
                   dir_rows[i].typed, dir_rows[i].want);

      run_phase(HALF_RESET, 0, 0, 250);
      run_phase(16'd1, 85, 0, 300);
      run_phase(16'd0, 0, 85, 250);
      run_phase(16'd2, 6, 6, 250);
      run_phase(16'hFFFF, 0, 0, 30);
      // shrink the half period under a running step
      run_phase(16'd3, 0, 85, 100);
      run_phase(16'd1, 6, 6, 70);

      push <= 1'b0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      while (bus_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
